>>> hdl/circ_pkg.sv
// ----------------------------------------------------------------------------
// circ_pkg: shared constants and types for the circle outline plotter
// Field widths, serial unit sizes and the sequencer state type.
// ----------------------------------------------------------------------------
package circ_pkg;

    // field widths
    localparam int COORD_BITS = 11;
    localparam int RAD_BITS   = 10;
    localparam int OUT_BITS   = 13;
    localparam int PIX_BITS   = 8;

    // derived widths for the serial units
    localparam int SQ_BITS    = 2 * RAD_BITS;     // radius squared
    localparam int OFF_BITS   = RAD_BITS + 1;     // offsets, rounded root
    localparam int REM_BITS   = RAD_BITS + 1;     // root remainder
    localparam int CNT_BITS   = $clog2(RAD_BITS); // serial step counter

    // eight symmetric pixels per offset pair
    localparam int K_BITS     = 3;
    localparam logic [K_BITS-1:0] PIX_LAST = K_BITS'(7);

    localparam logic [PIX_BITS-1:0] PIX_RESET = PIX_BITS'(255);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_EMIT
    } t_state;

endpackage

>>> hdl/circ_in_if.sv
// ----------------------------------------------------------------------------
// circ_in_if: command channel
// Carries start / step items with centre and radius.
// ----------------------------------------------------------------------------
interface circ_in_if import circ_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [RAD_BITS-1:0]   radius;

    modport source (output valid, action, center_x, center_y, radius, input ready);
    modport sink   (input valid, action, center_x, center_y, radius, output ready);
endinterface

>>> hdl/circ_out_if.sv
// ----------------------------------------------------------------------------
// circ_out_if: pixel channel
// Carries one pixel write per item.
// ----------------------------------------------------------------------------
interface circ_out_if import circ_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] pixel_x;
    logic signed [OUT_BITS-1:0] pixel_y;
    logic [PIX_BITS-1:0]        intensity;
    logic                       last_in_step;
    logic                       circle_done;

    modport source (output valid, pixel_x, pixel_y, intensity, last_in_step,
                    circle_done, input ready);
    modport sink   (input valid, pixel_x, pixel_y, intensity, last_in_step,
                    circle_done, output ready);
endinterface

>>> hdl/circ_sq.sv
// ----------------------------------------------------------------------------
// circ_sq: bit-serial squarer
// Shift-add square of the radius, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module circ_sq import circ_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [RAD_BITS-1:0] i_operand,
    output logic                o_done,
    output logic [SQ_BITS-1:0]  o_square
);

    logic                r_run, n_run;
    logic                r_done, n_done;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [SQ_BITS-1:0]  r_mcand, n_mcand;
    logic [RAD_BITS-1:0] r_mplier, n_mplier;
    logic [SQ_BITS-1:0]  r_acc, n_acc;

    // one partial product per cycle
    always_comb begin
        n_run    = r_run;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_acc    = r_acc;
        if (i_start) begin
            n_run    = 1'b1;
            n_cnt    = '0;
            n_mcand  = SQ_BITS'(i_operand);
            n_mplier = i_operand;
            n_acc    = '0;
        end else if (r_run) begin
            if (r_mplier[0]) begin
                n_acc = r_acc + r_mcand;
            end
            n_mcand  = {r_mcand[SQ_BITS-2:0], 1'b0};
            n_mplier = {1'b0, r_mplier[RAD_BITS-1:1]};
            n_cnt    = r_cnt + 1'b1;
            if (r_cnt == CNT_BITS'(RAD_BITS - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_cnt    <= n_cnt;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_acc    <= n_acc;
    end

    assign o_done   = r_done;
    assign o_square = r_acc;

endmodule

>>> hdl/circ_rroot.sv
// ----------------------------------------------------------------------------
// circ_rroot: digit-serial rounded square root
// Restoring root, two radicand bits in and one root bit out per cycle,
// then round half up from the remainder.
// ----------------------------------------------------------------------------
module circ_rroot import circ_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SQ_BITS-1:0]  i_value,
    output logic                o_done,
    output logic [OFF_BITS-1:0] o_root
);

    logic                r_run, n_run;
    logic                r_done, n_done;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [SQ_BITS-1:0]  r_val, n_val;
    logic [REM_BITS-1:0] r_rem, n_rem;
    logic [RAD_BITS-1:0] r_root, n_root;

    logic [REM_BITS+1:0] w_part;
    logic [REM_BITS+1:0] w_trial;

    // one root digit per cycle
    always_comb begin
        n_run   = r_run;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_val   = r_val;
        n_rem   = r_rem;
        n_root  = r_root;
        w_part  = {r_rem, r_val[SQ_BITS-1 -: 2]};
        w_trial = (REM_BITS + 2)'({r_root, 2'b01});
        if (i_start) begin
            n_run  = 1'b1;
            n_cnt  = '0;
            n_val  = i_value;
            n_rem  = '0;
            n_root = '0;
        end else if (r_run) begin
            n_val = {r_val[SQ_BITS-3:0], 2'b00};
            if (w_part >= w_trial) begin
                n_rem  = REM_BITS'(w_part - w_trial);
                n_root = {r_root[RAD_BITS-2:0], 1'b1};
            end else begin
                n_rem  = REM_BITS'(w_part);
                n_root = {r_root[RAD_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_BITS'(RAD_BITS - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_val  <= n_val;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    // round half up: remainder above floor root means the next integer
    assign o_done = r_done;
    assign o_root = OFF_BITS'(r_root) + OFF_BITS'(r_rem > OFF_BITS'(r_root));

endmodule

>>> hdl/circle_octant_rounded_plotter.sv
// ----------------------------------------------------------------------------
// circle_octant_rounded_plotter: circle outline generator
// A start or a step of an open circle yields one offset pair and eight symmetric pixels.
//
//   channel   dir  handshake            payload
//   i_item    in   valid / ready        action, center_x, center_y, radius
//   o_pixel   out  valid / ready        pixel_x, pixel_y, intensity, flags
//   cfg       in   i_cfg_we             i_cfg_wdata (pixel value)
//
// A step runs the serial root, latches it, emits the eight pixels and
// goes back to idle to take the next item. A start first runs the serial
// radius square and hands it to the root. Both serial units retire one
// bit per cycle. Synchronous reset clears the sequencer, busy flag and
// output valid. A stalled pixel holds; the next item is taken while the
// last pixel waits.
// ----------------------------------------------------------------------------
module circle_octant_rounded_plotter import circ_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [PIX_BITS-1:0] i_cfg_wdata,
    circ_in_if.sink             i_item,
    circ_out_if.source          o_pixel
);

    t_state r_state, n_state;

    logic                  r_busy, n_busy;
    logic                  r_last, n_last;
    logic [K_BITS-1:0]     r_k, n_k;
    logic [COORD_BITS-1:0] r_cx, n_cx;
    logic [COORD_BITS-1:0] r_cy, n_cy;
    logic [SQ_BITS-1:0]    r_r2, n_r2;
    logic [SQ_BITS-1:0]    r_sq_x, n_sq_x;
    logic [OFF_BITS-1:0]   r_off_x, n_off_x;
    logic [OFF_BITS-1:0]   r_off_y, n_off_y;
    logic [PIX_BITS-1:0]   r_pixel_value;

    logic                  r_out_valid, n_out_valid;
    logic [OUT_BITS-1:0]   r_px, n_px;
    logic [OUT_BITS-1:0]   r_py, n_py;
    logic [PIX_BITS-1:0]   r_int, n_int;
    logic                  r_lis, n_lis;
    logic                  r_cdone, n_cdone;

    logic                  w_sq_start, w_sq_done;
    logic [SQ_BITS-1:0]    w_square;
    logic                  w_root_start, w_root_done;
    logic [SQ_BITS-1:0]    w_root_val;
    logic [OFF_BITS-1:0]   w_root;
    logic [OFF_BITS-1:0]   w_dx, w_dy;

    circ_sq u_sq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_sq_start),
        .i_operand (i_item.radius),
        .o_done    (w_sq_done),
        .o_square  (w_square)
    );

    circ_rroot u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_value (w_root_val),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    // swap on the upper four pixels
    assign w_dx = r_k[2] ? r_off_y : r_off_x;
    assign w_dy = r_k[2] ? r_off_x : r_off_y;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_busy       = r_busy;
        n_last       = r_last;
        n_k          = r_k;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_r2         = r_r2;
        n_sq_x       = r_sq_x;
        n_off_x      = r_off_x;
        n_off_y      = r_off_y;
        n_out_valid  = r_out_valid;
        n_px         = r_px;
        n_py         = r_py;
        n_int        = r_int;
        n_lis        = r_lis;
        n_cdone      = r_cdone;
        w_sq_start   = 1'b0;
        w_root_start = 1'b0;
        w_root_val   = r_r2 - r_sq_x;

        if (r_out_valid && o_pixel.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_item.valid) begin
                    if (!i_item.action) begin
                        n_cx       = i_item.center_x;
                        n_cy       = i_item.center_y;
                        n_off_x    = '0;
                        n_sq_x     = '0;
                        n_busy     = 1'b1;
                        w_sq_start = 1'b1;
                        n_state    = ST_SQUARE;
                    end else if (r_busy) begin
                        w_root_start = 1'b1;
                        n_state      = ST_ROOT;
                    end
                end
            end
            ST_SQUARE: begin
                if (w_sq_done) begin
                    n_r2         = w_square;
                    w_root_val   = w_square;
                    w_root_start = 1'b1;
                    n_state      = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (w_root_done) begin
                    n_off_y = w_root;
                    // done once y falls below the next x
                    n_last  = (w_root <= r_off_x);
                    if (w_root <= r_off_x) begin
                        n_busy = 1'b0;
                    end
                    n_k     = '0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || o_pixel.ready) begin
                    n_out_valid = 1'b1;
                    n_px    = r_k[1] ? OUT_BITS'(r_cx) - OUT_BITS'(w_dx)
                                     : OUT_BITS'(r_cx) + OUT_BITS'(w_dx);
                    n_py    = r_k[0] ? OUT_BITS'(r_cy) - OUT_BITS'(w_dy)
                                     : OUT_BITS'(r_cy) + OUT_BITS'(w_dy);
                    n_int   = r_pixel_value;
                    n_lis   = (r_k == PIX_LAST);
                    n_cdone = (r_k == PIX_LAST) && r_last;
                    n_k     = r_k + 1'b1;
                    if (r_k == PIX_LAST) begin
                        // advance x and keep x squared incrementally
                        n_off_x = r_off_x + 1'b1;
                        n_sq_x  = r_sq_x + SQ_BITS'({r_off_x, 1'b1});
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_busy        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_pixel_value <= PIX_RESET;
            r_off_x       <= '0;
            r_off_y       <= '0;
            r_sq_x        <= '0;
            r_r2          <= '0;
            r_cx          <= '0;
            r_cy          <= '0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            r_off_x     <= n_off_x;
            r_off_y     <= n_off_y;
            r_sq_x      <= n_sq_x;
            r_r2        <= n_r2;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            if (i_cfg_we) begin
                r_pixel_value <= i_cfg_wdata;
            end
        end
        r_last  <= n_last;
        r_k     <= n_k;
        r_px    <= n_px;
        r_py    <= n_py;
        r_int   <= n_int;
        r_lis   <= n_lis;
        r_cdone <= n_cdone;
    end

    assign i_item.ready         = (r_state == ST_IDLE);
    assign o_pixel.valid        = r_out_valid;
    assign o_pixel.pixel_x      = $signed(r_px);
    assign o_pixel.pixel_y      = $signed(r_py);
    assign o_pixel.intensity    = r_int;
    assign o_pixel.last_in_step = r_lis;
    assign o_pixel.circle_done  = r_cdone;

`ifndef ASSERT_OFF
    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pixel.valid && o_pixel.circle_done |-> o_pixel.last_in_step)
        else $error("circle_done without last_in_step");

    a_sq_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_done |-> r_state == ST_SQUARE)
        else $error("squarer finished outside square phase");

    a_root_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_done |-> r_state == ST_ROOT)
        else $error("root finished outside root phase");

    a_emit_begin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ROOT && w_root_done |=> r_state == ST_EMIT && r_k == '0)
        else $error("pixel phase did not start at first pixel");
`endif

endmodule

>>> bench/circle_octant_rounded_plotter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circle_octant_rounded_plotter_tb: self-checking bench for the circle plotter
// Start and step items go in through a bursty driver. Each accepted item is
// run through a local model of the octant walk with the rounded integer root.
// That model queues the eight expected pixels per offset pair. A stalling
// monitor compares every output pixel field by field. Several intensity
// settings are used, with a directed opening and random circle runs.
// ----------------------------------------------------------------------------
module circle_octant_rounded_plotter_tb;
    import circ_pkg::*;

    localparam int SETTLE_CYCLES = 3 * RAD_BITS + 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int ITEMS_PER_SET = 40;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_STEP  = 1'b1
    } t_action;

    typedef struct packed {
        t_action               action;
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
        logic [RAD_BITS-1:0]   radius;
    } t_cmd;

    typedef struct {
        logic signed [OUT_BITS-1:0] pixel_x;
        logic signed [OUT_BITS-1:0] pixel_y;
        logic [PIX_BITS-1:0]        intensity;
        logic                       last_in_step;
        logic                       circle_done;
    } t_pixel;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [PIX_BITS-1:0] cfg_wdata;

    circ_in_if  item_if ();
    circ_out_if pixel_if ();

    circle_octant_rounded_plotter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_if),
        .o_pixel     (pixel_if)
    );

    // pending items and expected pixels
    t_cmd   cmd_queue[$];
    t_pixel pixel_queue[$];

    // plotter model state, updated on each accepted item
    logic                run_active      = 1'b0;
    int                  col_base        = 0;
    int                  row_base        = 0;
    int                  rad_sq          = 0;
    int                  off_x           = 0;
    logic [PIX_BITS-1:0] pix_value_model = PIX_RESET;

    // stimulus bookkeeping
    int gen_steps_left = 0;
    int gen_counted    = 0;
    int hold_requests  = 0;
    int settings_used  = 0;

    // coverage-ish counters for the summary
    int n_starts   = 0;
    int n_steps    = 0;
    int n_idle     = 0;
    int n_circles  = 0;
    int n_pixels   = 0;
    int mismatches = 0;
    int cycles     = 0;

    // round(sqrt(v)) with halves rounded up, built from a bitwise floor root
    function automatic int rounded_root(int v);
        int q;
        q = 0;
        for (int b = RAD_BITS; b >= 0; b--) begin
            int t;
            t = q | (1 << b);
            if (t * t <= v) q = t;
        end
        return (v - q * q > q) ? q + 1 : q;
    endfunction

    // number of items (start included) needed to finish a circle
    function automatic int circle_length(int r);
        int a, b, n;
        a = 0;
        n = 0;
        do begin
            b = rounded_root(r * r - a * a);
            a++;
            n++;
        end while (b >= a);
        return n;
    endfunction

    // model: one accepted item -> zero or eight expected pixels
    task automatic plot_item(t_cmd c);
        int a, b, dx, dy;
        logic fin;
        t_pixel p;
        if (c.action == ACT_START) begin
            col_base   = int'(c.center_x);
            row_base   = int'(c.center_y);
            rad_sq     = int'(c.radius) * int'(c.radius);
            off_x      = 0;
            run_active = 1'b1;
            n_starts++;
        end else if (!run_active) begin
            n_idle++;
            return;
        end else begin
            n_steps++;
        end
        a     = off_x;
        b     = rounded_root(rad_sq - a * a);
        off_x = a + 1;
        fin   = (b < off_x);
        if (fin) begin
            run_active = 1'b0;
            n_circles++;
        end
        // order: swap on bit 2, negate x on bit 1, negate y on bit 0
        for (int k = 0; k < 8; k++) begin
            dx = k[2] ? b : a;
            dy = k[2] ? a : b;
            p.pixel_x      = OUT_BITS'(k[1] ? col_base - dx : col_base + dx);
            p.pixel_y      = OUT_BITS'(k[0] ? row_base - dy : row_base + dy);
            p.intensity    = pix_value_model;
            p.last_in_step = (k == 7);
            p.circle_done  = (k == 7) && fin;
            pixel_queue.push_back(p);
        end
    endtask

    // queue one item; steps on an idle plotter are not counted
    task automatic push_item(t_cmd c);
        if (c.action == ACT_START) begin
            gen_steps_left = circle_length(int'(c.radius)) - 1;
            gen_counted++;
        end else if (gen_steps_left > 0) begin
            gen_steps_left--;
            gen_counted++;
        end
        cmd_queue.push_back(c);
    endtask

    // step with junk payload, which the plotter must ignore
    task automatic push_step();
        t_cmd c;
        c.action   = ACT_STEP;
        c.center_x = COORD_BITS'($urandom);
        c.center_y = COORD_BITS'($urandom);
        c.radius   = RAD_BITS'($urandom);
        push_item(c);
    endtask

    // start plus n steps; negative n runs the circle to completion
    task automatic push_circle(int cx, int cy, int r, int n);
        t_cmd c;
        c.action   = ACT_START;
        c.center_x = COORD_BITS'(cx);
        c.center_y = COORD_BITS'(cy);
        c.radius   = RAD_BITS'(r);
        push_item(c);
        if (n < 0) n = gen_steps_left;
        repeat (n) push_step();
    endtask

    // mostly whole circles with random content, some cut short, some noise
    task automatic random_items(int goal);
        int target, sel, pick, r, n;
        target = gen_counted + goal;
        while (gen_counted < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 85) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) r = $urandom_range(0, 12);
                else if (pick < 9) r = $urandom_range(13, 40);
                else r = $urandom_range(0, (1 << RAD_BITS) - 1);
                n = circle_length(r) - 1;
                // large radii and a few small ones get cut by the next start
                if (r > 40 || $urandom_range(0, 7) == 0)
                    n = $urandom_range(0, (n < 8) ? n : 8);
                push_circle($urandom_range(0, (1 << COORD_BITS) - 1),
                            $urandom_range(0, (1 << COORD_BITS) - 1), r, n);
            end else begin
                push_step();
            end
        end
    endtask

    // wait until all items are in and all pixels are out, then let it settle
    task automatic drain();
        while (cmd_queue.size() != 0 || item_if.valid === 1'b1 ||
               pixel_queue.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // intensity register write, only while the plotter is idle
    task automatic set_pixel_value(logic [PIX_BITS-1:0] v);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we          <= 1'b0;
        pix_value_model = v;
        settings_used++;
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // item driver: bursts of random length separated by random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin : item_driver
        t_cmd nxt;
        logic take;
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
            gap_left      <= 0;
        end else begin
            take = item_if.valid && item_if.ready;
            if (take)
                plot_item('{action:   t_action'(item_if.action),
                            center_x: item_if.center_x,
                            center_y: item_if.center_y,
                            radius:   item_if.radius});
            if (!item_if.valid || take) begin
                if (gap_left != 0) begin
                    gap_left      <= gap_left - 1;
                    item_if.valid <= 1'b0;
                end else if (cmd_queue.size() != 0) begin
                    nxt = cmd_queue.pop_front();
                    item_if.valid    <= 1'b1;
                    item_if.action   <= nxt.action;
                    item_if.center_x <= nxt.center_x;
                    item_if.center_y <= nxt.center_y;
                    item_if.radius   <= nxt.radius;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 :
                                      $urandom_range(1, 24);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // pixel monitor: checks each accepted pixel, stalls on a pattern of its own
    int hold_seen = 0;
    int hold_left = 0;
    int rx_mode   = 0;
    int mode_left = 0;

    always @(posedge i_clk) begin : pixel_monitor
        t_pixel want;
        if (!i_rst_n) begin
            pixel_if.ready <= 1'b0;
        end else begin
            if (pixel_if.valid && pixel_if.ready) begin
                n_pixels++;
                if (pixel_queue.size() == 0) begin
                    $error("unexpected pixel (%0d, %0d) with nothing pending",
                           pixel_if.pixel_x, pixel_if.pixel_y);
                    mismatches++;
                end else begin
                    want = pixel_queue.pop_front();
                    if (pixel_if.pixel_x !== want.pixel_x) begin
                        $error("pixel_x mismatch: expected %0d, got %0d",
                               want.pixel_x, pixel_if.pixel_x);
                        mismatches++;
                    end
                    if (pixel_if.pixel_y !== want.pixel_y) begin
                        $error("pixel_y mismatch: expected %0d, got %0d",
                               want.pixel_y, pixel_if.pixel_y);
                        mismatches++;
                    end
                    if (pixel_if.intensity !== want.intensity) begin
                        $error("intensity mismatch: expected %0d, got %0d",
                               want.intensity, pixel_if.intensity);
                        mismatches++;
                    end
                    if (pixel_if.last_in_step !== want.last_in_step) begin
                        $error("last_in_step mismatch: expected %0b, got %0b",
                               want.last_in_step, pixel_if.last_in_step);
                        mismatches++;
                    end
                    if (pixel_if.circle_done !== want.circle_done) begin
                        $error("circle_done mismatch: expected %0b, got %0b",
                               want.circle_done, pixel_if.circle_done);
                        mismatches++;
                    end
                end
            end
            // long hold-off on request, else a randomly chosen stall mode
            if (hold_seen != hold_requests) begin
                hold_seen      <= hold_requests;
                hold_left      <= HOLD_CYCLES;
                pixel_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left      <= hold_left - 1;
                pixel_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   <= $urandom_range(0, 3);
                    mode_left <= $urandom_range(20, 80);
                end else begin
                    mode_left <= mode_left - 1;
                end
                case (rx_mode)
                    0:       pixel_if.ready <= 1'b1;
                    1:       pixel_if.ready <= 1'($urandom_range(0, 1));
                    2:       pixel_if.ready <= ($urandom_range(0, 3) == 0);
                    default: pixel_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // reset, directed opening, then random phases at several intensities
    initial begin : stimulus
        logic [PIX_BITS-1:0] levels[4];
        int leftover;
        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset intensity
        push_step();                          // step while idle
        push_circle(0, 0, 0, -1);             // zero radius, done at once
        push_step();                          // step after the circle is done
        push_circle(5, 7, 1, -1);
        push_circle(0, 0, 1023, 2);           // negative coordinates
        push_circle(2047, 2047, 1023, 2);     // start while busy, past the raster
        push_circle(1024, 3, 2, -1);
        push_circle(2047, 0, 5, -1);
        push_circle(682, 1365, 10'h155, 1);
        drain();

        levels = '{8'h00, 8'hFF, 8'h01, 8'h80};
        levels[3] = PIX_BITS'($urandom);
        for (int ph = 0; ph < 4; ph++) begin
            set_pixel_value(levels[ph]);
            if (ph == 1) hold_requests++;
            random_items(ITEMS_PER_SET);
            drain();
        end

        leftover = pixel_queue.size();
        if (leftover != 0) $error("%0d expected pixels never arrived", leftover);

        $display("Drove %0d starts, %0d steps and %0d idle steps; %0d circles finished.",
                 n_starts, n_steps, n_idle, n_circles);
        $display("Checked %0d pixels over %0d intensity writes, incl. a long output hold-off.",
                 n_pixels, settings_used);
        if (mismatches == 0 && leftover == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
